[rtl/wds_pkg.sv]
package wds_pkg;

    // Image geometry limits
    localparam int MAX_WIDTH    = 128;
    localparam int MAX_HEIGHT   = 128;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_RADIUS   = 8;

    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int P_W     = $clog2(MAX_CHANNELS);
    localparam int ADDR_W  = P_W + Y_W + X_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int DATA_W  = 32;

    // Accumulator holds up to (2R+1)^2 differences of 33 bits
    localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int ACC_W   = DATA_W + 1 + $clog2(WIN_MAX);
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = ACC_W + GAIN_W + 1;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = PROD_W - FRAC_W;
    localparam int R_W     = Q_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Command modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_SAT     = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [6:0]         pos_x;
        logic [6:0]         pos_y;
        logic [1:0]         plane;
        logic signed [31:0] pixel_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] updated_value;
        logic [1:0]         status;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_WIN,
        ST_DRAIN,
        ST_MUL,
        ST_ROUND,
        ST_FIN
    } wds_state_t;

endpackage

[rtl/wds_ram.sv]
module wds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/window_difference_smoother.sv]
// Load: the pixel is written at the accept edge if inside the image; busy never rises.
// Query inside the image: states center, window (one RAM read per clipped window pixel),
//   drain, multiply, round and finish, then done pulses; next start in the done cycle.
// Query outside the image: finish state only, then done pulses, status outside.
// Reset (rst_n low, async) resets sequencer and config registers; image RAM is not
//   cleared. The receiver cannot stall: done is a one-cycle strobe.
module window_difference_smoother (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  wds_pkg::cmd_t                     cmd,
    output logic                              done,
    output wds_pkg::res_t                     result,
    input  logic                              cfg_we,
    input  logic [wds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wds_pkg::*;

    // Configuration registers
    logic [7:0]        width_reg;
    logic [7:0]        height_reg;
    logic [2:0]        chan_reg;
    logic [3:0]        radius_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Sequencer and datapath registers
    wds_state_t state_reg, state_next;
    cmd_t       cmd_reg;
    logic       outside_reg;
    logic [X_W-1:0] x0_reg, x1_reg, i_reg;
    logic [Y_W-1:0] y1_reg, j_reg;
    logic       rd_valid_reg, rd_center_reg;
    logic signed [DATA_W-1:0] center_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    q_reg;
    res_t       result_reg;
    logic       done_reg;

    // Effective (clamped) configuration
    logic [7:0] w_eff, h_eff;
    logic [2:0] c_eff;
    logic [3:0] r_eff;

    always_comb
    begin
        if (width_reg == 8'd0)
            w_eff = 8'd1;
        else if (width_reg > 8'(MAX_WIDTH))
            w_eff = 8'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 8'd0)
            h_eff = 8'd1;
        else if (height_reg > 8'(MAX_HEIGHT))
            h_eff = 8'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        if (chan_reg == 3'd0)
            c_eff = 3'd1;
        else if (chan_reg > 3'(MAX_CHANNELS))
            c_eff = 3'(MAX_CHANNELS);
        else
            c_eff = chan_reg;
        r_eff = (radius_reg > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_reg;
    end

    // Accept and range check on the incoming command
    logic accept;
    logic in_inside;
    assign accept    = start && !busy;
    assign in_inside = ({1'b0, cmd.pos_x} < w_eff) && ({1'b0, cmd.pos_y} < h_eff)
                       && ({1'b0, cmd.plane} < c_eff);

    // Window bounds from the latched center, clipped to the image
    logic [7:0]     xr_sum, yr_sum;
    logic [X_W-1:0] x0_next, x1_next;
    logic [Y_W-1:0] y0_next, y1_next;

    always_comb
    begin
        xr_sum  = {1'b0, cmd_reg.pos_x} + {4'd0, r_eff};
        yr_sum  = {1'b0, cmd_reg.pos_y} + {4'd0, r_eff};
        x0_next = ({3'd0, r_eff} < cmd_reg.pos_x) ? cmd_reg.pos_x - {3'd0, r_eff} : '0;
        y0_next = ({3'd0, r_eff} < cmd_reg.pos_y) ? cmd_reg.pos_y - {3'd0, r_eff} : '0;
        x1_next = (xr_sum < w_eff) ? xr_sum[X_W-1:0] : X_W'(w_eff - 8'd1);
        y1_next = (yr_sum < h_eff) ? yr_sum[Y_W-1:0] : Y_W'(h_eff - 8'd1);
    end

    // RAM port: loads from the command port in idle, reads from the sequencer otherwise
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    wds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.pixel_value),
        .rdata (ram_rdata)
    );

    // Sequencer: next state and RAM control
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_addr   = {cmd.plane, cmd.pos_y, cmd.pos_x};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == MODE_LOAD)
                        ram_we = in_inside;
                    else if (in_inside)
                        state_next = ST_CENTER;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_CENTER:
            begin
                ram_addr   = {cmd_reg.plane, cmd_reg.pos_y, cmd_reg.pos_x};
                state_next = ST_WIN;
            end
            ST_WIN:
            begin
                ram_addr = {cmd_reg.plane, j_reg, i_reg};
                if (i_reg == x1_reg && j_reg == y1_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rd_center_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= (state_reg == ST_FIN);
            rd_valid_reg  <= (state_reg == ST_CENTER) || (state_reg == ST_WIN);
            rd_center_reg <= (state_reg == ST_CENTER);
        end
    end

    // Configuration writes; out-of-list indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            chan_reg   <= 3'd3;
            radius_reg <= 4'd1;
            gain_reg   <= 16'd655;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:    width_reg  <= cfg_data[7:0];
                CFG_HEIGHT:   height_reg <= cfg_data[7:0];
                CFG_CHANNELS: chan_reg   <= cfg_data[2:0];
                CFG_RADIUS:   radius_reg <= cfg_data[3:0];
                CFG_GAIN:     gain_reg   <= cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Datapath
    logic signed [DATA_W:0]   diff;
    logic signed [PROD_W-1:0] rounded;
    logic signed [R_W-1:0]    sum_r;

    always_comb
    begin
        diff    = $signed({ram_rdata[DATA_W-1], ram_rdata})
                  - $signed({center_reg[DATA_W-1], center_reg});
        rounded = prod_reg + PROD_W'(32768);
        sum_r   = R_W'(cmd_reg.pixel_value) + R_W'(q_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == MODE_QUERY)
        begin
            cmd_reg     <= cmd;
            outside_reg <= !in_inside;
        end
        if (state_reg == ST_CENTER)
        begin
            x0_reg  <= x0_next;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            i_reg   <= x0_next;
            j_reg   <= y0_next;
            acc_reg <= '0;
        end
        else if (state_reg == ST_WIN)
        begin
            // raster walk over the clipped window
            if (i_reg == x1_reg)
            begin
                i_reg <= x0_reg;
                j_reg <= j_reg + 1'b1;
            end
            else
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
        // Read data arrives the cycle after its address (registered RAM); center arrives first
        if (rd_valid_reg)
        begin
            if (rd_center_reg)
                center_reg <= ram_rdata;
            else
                acc_reg <= acc_reg + ACC_W'(diff);
        end
        if (state_reg == ST_MUL)
            prod_reg <= acc_reg * $signed({1'b0, gain_reg});
        if (state_reg == ST_ROUND)
            q_reg <= rounded[PROD_W-1:FRAC_W];  // floor after +0.5: ties round up
        if (state_reg == ST_FIN)
        begin
            if (outside_reg)
            begin
                result_reg.updated_value <= cmd_reg.pixel_value;
                result_reg.status        <= STAT_OUTSIDE;
            end
            else if (sum_r[R_W-1:DATA_W-1] != {(R_W-DATA_W+1){sum_r[R_W-1]}})
            begin
                result_reg.updated_value <= sum_r[R_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                result_reg.status        <= STAT_SAT;
            end
            else
            begin
                result_reg.updated_value <= sum_r[DATA_W-1:0];
                result_reg.status        <= STAT_OK;
            end
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Assertions
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_IDLE)
        else $error("image write outside idle");

    a_center_then_win: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CENTER |=> state_reg == ST_WIN && rd_center_reg)
        else $error("center read not followed by window walk");

    a_win_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WIN |-> i_reg >= x0_reg && i_reg <= x1_reg && j_reg <= y1_reg)
        else $error("window walk out of bounds");

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> done)
        else $error("missing result strobe");

endmodule

[tb/window_difference_smoother_tb.sv]
`timescale 1ns / 1ps

module window_difference_smoother_tb;

    import wds_pkg::*;

    // No transfer in this many cycles means the block has hung.
    // The slowest query is a full 17x17 window.
    localparam int STALL_LIMIT  = 2000;
    // Cycles allowed after the last result before a register write or the
    // end: covers a trailing load or an outside query.
    localparam int DRAIN_CYCLES = 16;

    localparam longint Q16_MAX = 64'sd2147483647;
    localparam longint Q16_MIN = -64'sd2147483648;

    // Inputs of the block, known from time zero
    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         start     = 1'b0;
    cmd_t         cmd       = '0;
    logic         cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic         busy;
    logic         done;
    res_t         result;

    window_difference_smoother uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Local copy of the configuration registers, raw (masked to width only).
    // Reset values match the block's.
    bit [7:0]  reg_width  = 8'd128;
    bit [7:0]  reg_height = 8'd128;
    bit [2:0]  reg_planes = 3'd3;
    bit [3:0]  reg_radius = 4'd1;
    bit [15:0] reg_gain   = 16'd655;

    // Predicted image contents, updated as loads are transferred
    logic signed [31:0] image_mem [0:DEPTH-1];
    // Pixels the generator has already loaded; queries never touch others
    bit pixel_loaded [0:DEPTH-1];

    cmd_t command_backlog [$];   // commands waiting to be driven
    res_t expected_updates [$];  // predicted results, oldest first

    int idle_pct    = 34;        // chance in percent that the driver holds off
    int errors      = 0;
    int stall_count = 0;
    int anchor_x, anchor_y, anchor_p;

    // ------------------------------------------------------------------
    // Geometry in effect: zero counts as one, sizes clip at the maximum
    // ------------------------------------------------------------------
    function automatic int eff_width();
        return (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width);
    endfunction

    function automatic int eff_height();
        return (reg_height == 0) ? 1 : ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height);
    endfunction

    function automatic int eff_planes();
        return (reg_planes == 0) ? 1
                                 : ((reg_planes > MAX_CHANNELS) ? MAX_CHANNELS : reg_planes);
    endfunction

    function automatic int eff_radius();
        return (reg_radius > MAX_RADIUS) ? MAX_RADIUS : reg_radius;
    endfunction

    function automatic bit is_inside(int x, int y, int p);
        return x < eff_width() && y < eff_height() && p < eff_planes();
    endfunction

    function automatic int addr_of(int x, int y, int p);
        return x + MAX_WIDTH * (y + MAX_HEIGHT * p);
    endfunction

    // Square window around (x, y), clipped to the image
    function automatic void window_bounds(input int x, input int y,
                                          output int x0, output int x1,
                                          output int y0, output int y1);
        int rad;
        rad = eff_radius();
        x0 = (x > rad) ? x - rad : 0;
        y0 = (y > rad) ? y - rad : 0;
        x1 = (x + rad < eff_width())  ? x + rad : eff_width() - 1;
        y1 = (y + rad < eff_height()) ? y + rad : eff_height() - 1;
    endfunction

    // Expected result of a query: U + round(gain * sum(neighbour - centre)),
    // rounding half toward plus infinity, saturating to Q16.16.
    function automatic res_t smoothed_update(cmd_t c);
        res_t   upd;
        int     cx, cy, cp, x0, x1, y0, y1;
        longint centre, diff_sum, scaled, total;
        cx = c.pos_x;
        cy = c.pos_y;
        cp = c.plane;
        if (!is_inside(cx, cy, cp))
        begin
            upd.updated_value = c.pixel_value;
            upd.status        = STAT_OUTSIDE;
            return upd;
        end
        centre   = longint'(image_mem[addr_of(cx, cy, cp)]);
        diff_sum = 0;
        window_bounds(cx, cy, x0, x1, y0, y1);
        for (int j = y0; j <= y1; j++)
            for (int i = x0; i <= x1; i++)
                diff_sum += longint'(image_mem[addr_of(i, j, cp)]) - centre;
        // Arithmetic shift is a floor, so adding half first rounds ties up
        scaled = diff_sum * longint'(reg_gain) + (64'sd1 <<< (FRAC_W - 1));
        total  = longint'(c.pixel_value) + (scaled >>> FRAC_W);
        upd.status = STAT_OK;
        if (total > Q16_MAX)
        begin
            total      = Q16_MAX;
            upd.status = STAT_SAT;
        end
        else if (total < Q16_MIN)
        begin
            total      = Q16_MIN;
            upd.status = STAT_SAT;
        end
        upd.updated_value = total[31:0];
        return upd;
    endfunction

    // Update the image copy or predict a result for one transferred command
    function automatic void absorb_command(cmd_t c);
        if (c.mode == MODE_LOAD)
        begin
            if (is_inside(c.pos_x, c.pos_y, c.plane))
                image_mem[addr_of(c.pos_x, c.pos_y, c.plane)] = c.pixel_value;
        end
        else
            expected_updates.push_back(smoothed_update(c));
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the backlog head, drops start between commands
    // at random. A single nonblocking write to start per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : command_driver
        bit next_start;
        if (rst_n)
        begin
            next_start = start;
            if (start && !busy)
            begin
                absorb_command(command_backlog.pop_front());
                next_start = 1'b0;
            end
            if (!next_start && command_backlog.size() != 0
                && $urandom_range(99) >= idle_pct)
            begin
                next_start = 1'b1;
                cmd <= command_backlog[0];
            end
            start <= next_start;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, taken at the edge ending it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && done)
        begin
            if (expected_updates.size() == 0)
            begin
                $display("%0t: unexpected result value %h status %0d",
                         $time, result.updated_value, result.status);
                errors++;
            end
            else
            begin
                want = expected_updates.pop_front();
                if (result.updated_value !== want.updated_value
                    || result.status !== want.status)
                begin
                    $display("%0t: value exp %h got %h, status exp %0d got %0d",
                             $time, want.updated_value, result.updated_value,
                             want.status, result.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin : stall_watch
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count <= 0;
            else if (stall_count >= STALL_LIMIT)
            begin
                $display("window_difference_smoother: mismatch");
                $finish;
            end
            else
                stall_count <= stall_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_t make_cmd(logic mode, int x, int y, int p,
                                      logic signed [31:0] value);
        cmd_t c;
        c.mode        = mode;
        c.pos_x       = x[6:0];
        c.pos_y       = y[6:0];
        c.plane       = p[1:0];
        c.pixel_value = value;
        return c;
    endfunction

    // Q16.16 values weighted toward the extremes and small magnitudes
    function automatic logic signed [31:0] random_q16();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0;
            3, 4: v = {{12{v[19]}}, v[19:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic int near(int centre, int size);
        int v;
        v = centre + int'($urandom_range(6)) - 3;
        return (v < 0) ? 0 : ((v >= size) ? size - 1 : v);
    endfunction

    task automatic queue_load(int x, int y, int p, logic signed [31:0] value);
        command_backlog.push_back(make_cmd(MODE_LOAD, x, y, p, value));
        if (is_inside(x, y, p))
            pixel_loaded[addr_of(x, y, p)] = 1'b1;
    endtask

    // A query inside the image first loads any window pixel not yet written
    task automatic queue_query(int x, int y, int p, logic signed [31:0] upd);
        int x0, x1, y0, y1;
        if (is_inside(x, y, p))
        begin
            window_bounds(x, y, x0, x1, y0, y1);
            for (int j = y0; j <= y1; j++)
                for (int i = x0; i <= x1; i++)
                    if (!pixel_loaded[addr_of(i, j, p)])
                        queue_load(i, j, p, random_q16());
        end
        command_backlog.push_back(make_cmd(MODE_QUERY, x, y, p, upd));
    endtask

    task automatic random_item();
        int x, y, p;
        bit is_query;
        is_query = $urandom_range(99) < 55;
        if ($urandom_range(99) < 15)
        begin
            // any coordinate, mostly outside on small images
            x = $urandom_range(127);
            y = $urandom_range(127);
            p = $urandom_range(3);
        end
        else if ($urandom_range(99) < 70)
        begin
            // cluster around the anchor so windows overlap
            x = near(anchor_x, eff_width());
            y = near(anchor_y, eff_height());
            p = anchor_p;
        end
        else
        begin
            x = $urandom_range(eff_width() - 1);
            y = $urandom_range(eff_height() - 1);
            p = $urandom_range(eff_planes() - 1);
        end
        if (is_query)
            queue_query(x, y, p, random_q16());
        else
            queue_load(x, y, p, random_q16());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_WIDTH:    reg_width  = data[7:0];
            CFG_HEIGHT:   reg_height = data[7:0];
            CFG_CHANNELS: reg_planes = data[2:0];
            CFG_RADIUS:   reg_radius = data[3:0];
            CFG_GAIN:     reg_gain   = data[15:0];
            default: ;
        endcase
    endtask

    // Wait until every command is transferred and every result is back
    task automatic wait_idle();
        while (command_backlog.size() != 0 || expected_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(logic [15:0] w, logic [15:0] h, logic [15:0] planes,
                                    logic [15:0] rad, logic [15:0] gain,
                                    int item_count, int pct);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CHANNELS, planes);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_GAIN, gain);
        idle_pct = pct;
        anchor_x = $urandom_range(eff_width() - 1);
        anchor_y = $urandom_range(eff_height() - 1);
        anchor_p = $urandom_range(eff_planes() - 1);
        while (command_backlog.size() < item_count)
            random_item();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: 128x128, three planes, radius 1, gain 655.
        // Full-scale pixels at the top-left corner, an outside plane,
        // an ignored outside load, and the far corners.
        queue_load(0, 0, 0, 32'h7FFF_FFFF);
        queue_load(1, 0, 0, 32'h8000_0000);
        queue_load(0, 1, 0, 32'h0);
        queue_load(1, 1, 0, 32'hFFFF_FFFF);
        queue_query(0, 0, 0, 32'h0);
        queue_query(1, 0, 0, 32'h7FFF_0000);
        queue_query(5, 5, 3, 32'h8000_0000);
        queue_load(5, 5, 3, 32'h1234_5678);
        queue_query(127, 127, 2, 32'h7FFF_FFFF);
        queue_query(0, 127, 1, 32'h0);
        wait_idle();

        // Gain of one half: a sum of +1 rounds up to 1, -1 rounds up to 0
        write_reg(CFG_GAIN, 16'h8000);
        queue_load(0, 0, 1, 32'h0);
        queue_load(1, 0, 1, 32'h1);
        queue_load(0, 1, 1, 32'h0);
        queue_load(1, 1, 1, 32'h0);
        queue_query(0, 0, 1, 32'h5);
        queue_load(127, 0, 1, 32'h0);
        queue_load(126, 0, 1, 32'hFFFF_FFFF);
        queue_load(126, 1, 1, 32'h0);
        queue_load(127, 1, 1, 32'h0);
        queue_query(127, 0, 1, 32'h5);
        wait_idle();

        // Full gain: drive the sum past both Q16.16 limits
        write_reg(CFG_GAIN, 16'hFFFF);
        queue_load(0, 0, 2, 32'h8000_0000);
        queue_load(1, 0, 2, 32'h7FFF_FFFF);
        queue_load(0, 1, 2, 32'h7FFF_FFFF);
        queue_load(1, 1, 2, 32'h7FFF_FFFF);
        queue_query(0, 0, 2, 32'h7FFF_FFFF);
        queue_load(127, 127, 2, 32'h7FFF_FFFF);
        queue_load(126, 127, 2, 32'h8000_0000);
        queue_load(127, 126, 2, 32'h8000_0000);
        queue_load(126, 126, 2, 32'h8000_0000);
        queue_query(127, 127, 2, 32'h8000_0000);
        wait_idle();

        // Random phases: sender idles 34%, then 74%, then not at all
        run_random_phase(16'd8, 16'd6, 16'd2, 16'd1, 16'($urandom_range(65535)), 130, 34);

        // Indexes past the register list must change nothing
        for (int idx = CFG_GAIN + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), 16'($urandom));

        // Out-of-range writes: masked zero sizes become 1x1x1, radius 15 clips to 8
        run_random_phase(16'hFF00, 16'h0000, 16'h0008, 16'h00FF, 16'h0000, 50, 34);
        run_random_phase(16'd128, 16'd128, 16'd4, 16'd0, 16'hFFFF, 150, 74);
        run_random_phase(16'd200, 16'd3, 16'd7, 16'd8, 16'($urandom_range(65535)), 120, 74);
        run_random_phase(16'd5, 16'd9, 16'd4, 16'd9, 16'($urandom_range(65535)), 120, 0);
        run_random_phase(16'd128, 16'd128, 16'd1, 16'd2, 16'd1, 130, 0);

        if (errors == 0)
            $display("window_difference_smoother: match");
        else
            $display("window_difference_smoother: mismatch");
        $finish;
    end

endmodule

[window_difference_smoother.f]
rtl/wds_pkg.sv
rtl/wds_ram.sv
rtl/window_difference_smoother.sv
tb/window_difference_smoother_tb.sv
